FILE: rtl/core/sida_pkg.sv
// Shared constants and control types for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sida_pkg;

    // Default width of the signed input value.
    localparam int VALUE_WIDTH_DEF = 32;

    // Output character width and the ASCII codes that are produced.
    localparam int          CHAR_W   = 6;
    localparam logic [5:0]  CH_ZERO  = 6'd48;
    localparam logic [5:0]  CH_MINUS = 6'd45;

    // One packed decimal digit and the shift-add-3 correction constants.
    localparam int          DIGIT_W   = 4;
    localparam logic [3:0]  ADJ_LIMIT = 4'd5;
    localparam logic [3:0]  ADJ_ADD   = 4'd3;

    // Commands from the sequencer to the digit converter.
    typedef struct packed {
        logic load;         // Start a new conversion from load_mag.
        logic digit_shift;  // Move the digit register up by one digit.
    } dab_ctl_t;

    // Status from the digit converter back to the sequencer.
    typedef struct packed {
        logic                done;       // One-cycle pulse: digits are ready.
        logic [DIGIT_W-1:0]  top_digit;  // Most significant digit held.
    } dab_stat_t;

endpackage

FILE: rtl/core/sida_dabble.sv
// Bit-serial binary to packed decimal converter using the shift-add-3 method.
`timescale 1ns / 1ps

module sida_dabble #(
    parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sida_pkg::dab_ctl_t     ctl,
    input  logic [VALUE_WIDTH-1:0] load_mag,
    output sida_pkg::dab_stat_t    stat
);
    import sida_pkg::*;

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   run_reg;
    logic                   done_reg;

    // Each digit of five or more gets three added before the next doubling.
    always_comb begin
        logic [DIGIT_W-1:0] d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = bcd_reg[i*DIGIT_W +: DIGIT_W];
            bcd_adj[i*DIGIT_W +: DIGIT_W] = (d >= ADJ_LIMIT) ? d + ADJ_ADD : d;
        end
    end

    // Conversion steps one input bit per cycle, most significant bit first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.load) begin
                mag_reg <= load_mag;
                bcd_reg <= '0;
                cnt_reg <= CNT_W'(VALUE_WIDTH);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                bcd_reg <= {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_reg <= mag_reg << 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (ctl.digit_shift) begin
                bcd_reg <= bcd_reg << DIGIT_W;
            end
        end
    end

    assign stat.done      = done_reg;
    assign stat.top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

endmodule

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Sequence after accept: the bit-serial conversion steps, a hand-off into the digit stage,
// then the digit positions in order, most significant first; leading zeros are dropped
// without a beat, and a negative value puts a minus sign character first.
// A new number is taken only in idle, after the last character of the previous one has been
// registered; the output holds while m_ready is low.
// Reset: synchronous active-low aresetn returns the sequencer to idle and drops m_valid.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sida_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_last
);
    import sida_pkg::*;

    // Enough digits for the magnitude of the most negative value.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;
    logic                started_reg, started_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;
    logic                out_free;
    logic                is_last_digit;
    logic [VALUE_WIDTH-1:0] load_mag;
    dab_ctl_t            dab_ctl;
    dab_stat_t           dab_stat;

    sida_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dab_ctl),
        .load_mag (load_mag),
        .stat     (dab_stat)
    );

    // Magnitude as an unsigned quantity; the most negative value maps to 2^(W-1).
    assign load_mag = s_value[VALUE_WIDTH-1] ? (~s_value + VALUE_WIDTH'(1)) : s_value;

    // The output register can take a new beat when empty or being drained.
    assign out_free      = !m_valid_reg || m_ready;
    assign is_last_digit = (dcnt_reg == DCNT_W'(1));

    // Sequencer: accept, convert, optional sign, then digits most significant first.
    always_comb begin
        state_next          = state_reg;
        neg_next            = neg_reg;
        started_next        = started_reg;
        dcnt_next           = dcnt_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_char_next         = m_char_reg;
        m_last_next         = m_last_reg;
        dab_ctl.load        = 1'b0;
        dab_ctl.digit_shift = 1'b0;
        s_ready             = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    neg_next     = s_value[VALUE_WIDTH-1];
                    dab_ctl.load = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                if (dab_stat.done) begin
                    dcnt_next    = DCNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CH_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!started_reg && dab_stat.top_digit == '0 && !is_last_digit) begin
                    // Leading zero: drop it without a beat.
                    dab_ctl.digit_shift = 1'b1;
                    dcnt_next           = dcnt_reg - DCNT_W'(1);
                end else if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_char_next         = CH_ZERO + {2'b00, dab_stat.top_digit};
                    m_last_next         = is_last_digit;
                    dab_ctl.digit_shift = 1'b1;
                    dcnt_next           = dcnt_reg - DCNT_W'(1);
                    started_next        = 1'b1;
                    if (is_last_digit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            started_reg <= 1'b0;
            neg_reg     <= 1'b0;
            dcnt_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            started_reg <= started_next;
            neg_reg     <= neg_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    // Output beat payload.
    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

endmodule
